// ===== hdl/indexed_min_heap_core_macros.svh =====
// ----------------------------------------------------------------------------
// Indexed min-heap assertion macros
// Shorthand for clocked implications checked under the block's reset.
// ----------------------------------------------------------------------------
`ifndef INDEXED_MIN_HEAP_CORE_MACROS_SVH
`define INDEXED_MIN_HEAP_CORE_MACROS_SVH

// Same-cycle implication
`define IMH_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define IMH_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/idxh_pkg.sv =====
// ----------------------------------------------------------------------------
// Indexed min-heap package
// Sizes, request and status codes and the heap entry type.
// ----------------------------------------------------------------------------
package idxh_pkg;

	// Sizes
	localparam int CAPACITY = 256;
	localparam int PRIO_W   = 32;
	localparam int KEY_W    = 8;
	localparam int NKEYS    = 1 << KEY_W;
	localparam int POS_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int CHILD_W  = POS_W + 2;

	// Request codes
	localparam logic [1:0] REQ_PUSH  = 2'd0;
	localparam logic [1:0] REQ_POP   = 2'd1;
	localparam logic [1:0] REQ_DEC   = 2'd2;
	localparam logic [1:0] REQ_CLEAR = 2'd3;

	// Status codes
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_EMPTY   = 3'd1;
	localparam logic [2:0] ST_FULL    = 3'd2;
	localparam logic [2:0] ST_DUP     = 3'd3;
	localparam logic [2:0] ST_BAD_DEC = 3'd4;

	// One heap slot: key and its priority kept side by side
	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [PRIO_W-1:0] prio;
	} heap_entry_t;

endpackage

// ===== hdl/indexed_min_heap_core.sv =====
// ----------------------------------------------------------------------------
// Indexed min-heap core
// Binary min-heap of keys with priorities, a key-to-position map and
// presence bits; push, pop minimum, decrease priority and clear.
// ----------------------------------------------------------------------------
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+-----------------------------------------
//  request | req_valid | req_stall | req_type, key, priority_req
//  result  | rsp_valid | rsp_stall | popped_key, popped_priority, status,
//          |           |           | entry_count
//
//  Clear, full push, duplicate push, empty pop and decrease of an absent
//  key go straight from idle to the finish step; push, decrease and pop
//  work on the heap. Sift-up and sift-down visit each heap level with a
//  heap memory read, then a compare and write-back.
//  One request is in flight at a time; the next is taken while a result
//  still waits in the output register. A stalled result holds the block in
//  its finish step.
//  Reset clears the presence bits and the count; the memories need no clear.
//
module indexed_min_heap_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_stall,
	input  logic [1:0]                req_type,
	input  logic [7:0]                key,
	input  logic [31:0]               priority_req,
	output logic                      rsp_valid,
	input  logic                      rsp_stall,
	output logic [7:0]                popped_key,
	output logic [31:0]               popped_priority,
	output logic [2:0]                status,
	output logic [8:0]                entry_count
);

`include "indexed_min_heap_core_macros.svh"

	// Sequencer states
	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_POP_RD  = 4'd1;
	localparam logic [3:0] S_POP_WB  = 4'd2;
	localparam logic [3:0] S_DEC_RD  = 4'd3;
	localparam logic [3:0] S_DEC_RD2 = 4'd4;
	localparam logic [3:0] S_DEC_CMP = 4'd5;
	localparam logic [3:0] S_SU_RD   = 4'd6;
	localparam logic [3:0] S_SU_CMP  = 4'd7;
	localparam logic [3:0] S_SD_RD   = 4'd8;
	localparam logic [3:0] S_SD_CMP  = 4'd9;
	localparam logic [3:0] S_DONE    = 4'd10;

	// Memories
	idxh_pkg::heap_entry_t heap_mem [idxh_pkg::CAPACITY];
	logic [idxh_pkg::POS_W-1:0] kpos_mem [idxh_pkg::NKEYS];

	// Control and working registers
	logic [3:0]                      state_q;
	logic [idxh_pkg::CNT_W-1:0]      size_q;
	logic [idxh_pkg::NKEYS-1:0]      present_q;
	logic [idxh_pkg::POS_W-1:0]      pos_q;
	logic [idxh_pkg::POS_W-1:0]      child_q;
	logic                            right_ok_q;
	idxh_pkg::heap_entry_t           item_q;
	logic [idxh_pkg::KEY_W-1:0]      res_key_q;
	logic [31:0]                     res_prio_q;
	logic [2:0]                      res_status_q;

	// Output register
	logic                            rsp_valid_q;
	logic [7:0]                      popped_key_q;
	logic [31:0]                     popped_prio_q;
	logic [2:0]                      status_q;
	logic [8:0]                      entry_count_q;

	// Memory ports
	idxh_pkg::heap_entry_t           hp_rdata0_q;
	idxh_pkg::heap_entry_t           hp_rdata1_q;
	logic [idxh_pkg::POS_W-1:0]      hp_raddr0;
	logic [idxh_pkg::POS_W-1:0]      hp_raddr1;
	logic [idxh_pkg::POS_W-1:0]      kp_rdata_q;
	logic                            wr_en;
	logic [idxh_pkg::POS_W-1:0]      wr_pos;
	idxh_pkg::heap_entry_t           wr_entry;

	// Address and compare terms
	logic [idxh_pkg::POS_W-1:0]      parent;
	logic [idxh_pkg::CHILD_W-1:0]    child_l;
	logic [idxh_pkg::CHILD_W-1:0]    child_r;
	logic [idxh_pkg::CHILD_W-1:0]    size_x;
	logic                            left_ok;
	logic                            right_ok;
	logic                            up_move;
	logic                            take_r;
	logic                            lt_left;
	logic                            lt_right;
	logic                            sd_stop;
	logic                            out_free;

	assign req_stall = (state_q != S_IDLE);
	assign out_free  = !rsp_valid_q || !rsp_stall;

	// Tree addressing around the current position
	assign parent   = idxh_pkg::POS_W'((pos_q - idxh_pkg::POS_W'(1)) >> 1);
	assign child_l  = {1'b0, pos_q, 1'b1};
	assign child_r  = child_l + idxh_pkg::CHILD_W'(1);
	assign size_x   = idxh_pkg::CHILD_W'(size_q);
	assign left_ok  = child_l < size_x;
	assign right_ok = child_r < size_x;

	// Compares run in parallel; selection follows
	assign up_move  = item_q.prio < hp_rdata0_q.prio;
	assign take_r   = right_ok_q && (hp_rdata1_q.prio < hp_rdata0_q.prio);
	assign lt_left  = item_q.prio < hp_rdata0_q.prio;
	assign lt_right = item_q.prio < hp_rdata1_q.prio;
	assign sd_stop  = take_r ? lt_right : lt_left;

	// Heap read addresses per state
	always_comb begin
		hp_raddr0 = parent;
		hp_raddr1 = child_r[idxh_pkg::POS_W-1:0];
		case (state_q)
			S_POP_RD: begin
				hp_raddr0 = '0;
				hp_raddr1 = size_q[idxh_pkg::POS_W-1:0];
			end
			S_DEC_RD2: begin
				hp_raddr0 = kp_rdata_q;
			end
			S_SD_RD: begin
				hp_raddr0 = child_l[idxh_pkg::POS_W-1:0];
				hp_raddr1 = child_r[idxh_pkg::POS_W-1:0];
			end
			default: begin
				hp_raddr0 = parent;
			end
		endcase
	end

	// Write-back: one slot and its map entry per cycle. Read data that is used
	// is always read after the last write has landed, so no forwarding is needed.
	always_comb begin
		wr_en    = 1'b0;
		wr_pos   = pos_q;
		wr_entry = item_q;
		case (state_q)
			S_SU_RD: begin
				wr_en = (pos_q == '0);
			end
			S_SU_CMP: begin
				wr_en = 1'b1;
				if (up_move) begin
					wr_entry = hp_rdata0_q;
				end
			end
			S_SD_RD: begin
				wr_en = !left_ok;
			end
			S_SD_CMP: begin
				wr_en = 1'b1;
				if (!sd_stop) begin
					wr_entry = take_r ? hp_rdata1_q : hp_rdata0_q;
				end
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// Heap slot memory: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (wr_en) begin
			heap_mem[wr_pos] <= wr_entry;
		end
		hp_rdata0_q <= heap_mem[hp_raddr0];
		hp_rdata1_q <= heap_mem[hp_raddr1];
	end

	// Key-to-position memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			kpos_mem[wr_entry.key] <= wr_pos;
		end
		kp_rdata_q <= kpos_mem[item_q.key];
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			size_q        <= '0;
			present_q     <= '0;
			rsp_valid_q   <= 1'b0;
			pos_q         <= '0;
			child_q       <= '0;
			right_ok_q    <= 1'b0;
			item_q        <= '0;
			res_key_q     <= '0;
			res_prio_q    <= '0;
			res_status_q  <= idxh_pkg::ST_OK;
			popped_key_q  <= '0;
			popped_prio_q <= '0;
			status_q      <= idxh_pkg::ST_OK;
			entry_count_q <= '0;
		end else begin
			// Finish step reloads the output register itself
			if (rsp_valid_q && !rsp_stall && state_q != S_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						item_q <= {key, idxh_pkg::PRIO_W'(priority_req)};
						case (req_type)
							idxh_pkg::REQ_PUSH: begin
								if (size_q == idxh_pkg::CNT_W'(idxh_pkg::CAPACITY)) begin
									res_status_q <= idxh_pkg::ST_FULL;
									state_q      <= S_DONE;
								end else if (present_q[key]) begin
									res_status_q <= idxh_pkg::ST_DUP;
									state_q      <= S_DONE;
								end else begin
									present_q[key] <= 1'b1;
									pos_q          <= size_q[idxh_pkg::POS_W-1:0];
									size_q         <= size_q + idxh_pkg::CNT_W'(1);
									state_q        <= S_SU_RD;
								end
							end
							idxh_pkg::REQ_POP: begin
								if (size_q == '0) begin
									res_status_q <= idxh_pkg::ST_EMPTY;
									state_q      <= S_DONE;
								end else begin
									size_q  <= size_q - idxh_pkg::CNT_W'(1);
									state_q <= S_POP_RD;
								end
							end
							idxh_pkg::REQ_DEC: begin
								if (!present_q[key]) begin
									res_status_q <= idxh_pkg::ST_BAD_DEC;
									state_q      <= S_DONE;
								end else begin
									state_q <= S_DEC_RD;
								end
							end
							default: begin
								size_q    <= '0;
								present_q <= '0;
								state_q   <= S_DONE;
							end
						endcase
					end
				end
				S_POP_RD: begin
					state_q <= S_POP_WB;
				end
				// Top leaves; if any remain, the last slot moves to the root and sinks
				S_POP_WB: begin
					res_key_q                  <= hp_rdata0_q.key;
					res_prio_q                 <= 32'(hp_rdata0_q.prio);
					present_q[hp_rdata0_q.key] <= 1'b0;
					if (size_q == '0) begin
						state_q <= S_DONE;
					end else begin
						item_q  <= hp_rdata1_q;
						pos_q   <= '0;
						state_q <= S_SD_RD;
					end
				end
				S_DEC_RD: begin
					state_q <= S_DEC_RD2;
				end
				S_DEC_RD2: begin
					pos_q   <= kp_rdata_q;
					state_q <= S_DEC_CMP;
				end
				// New priority must be strictly lower
				S_DEC_CMP: begin
					if (up_move) begin
						state_q <= S_SU_RD;
					end else begin
						res_status_q <= idxh_pkg::ST_BAD_DEC;
						state_q      <= S_DONE;
					end
				end
				S_SU_RD: begin
					state_q <= (pos_q == '0) ? S_DONE : S_SU_CMP;
				end
				S_SU_CMP: begin
					if (up_move) begin
						pos_q   <= parent;
						state_q <= S_SU_RD;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_SD_RD: begin
					if (left_ok) begin
						child_q    <= child_l[idxh_pkg::POS_W-1:0];
						right_ok_q <= right_ok;
						state_q    <= S_SD_CMP;
					end else begin
						state_q <= S_DONE;
					end
				end
				// Equal priority keeps sinking
				S_SD_CMP: begin
					if (sd_stop) begin
						state_q <= S_DONE;
					end else begin
						pos_q   <= take_r ? child_q + idxh_pkg::POS_W'(1) : child_q;
						state_q <= S_SD_RD;
					end
				end
				// Hand the result over, then clear it for the next request
				S_DONE: begin
					if (out_free) begin
						rsp_valid_q   <= 1'b1;
						popped_key_q  <= res_key_q;
						popped_prio_q <= res_prio_q;
						status_q      <= res_status_q;
						entry_count_q <= 9'(size_q);
						res_key_q     <= '0;
						res_prio_q    <= '0;
						res_status_q  <= idxh_pkg::ST_OK;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid       = rsp_valid_q;
	assign popped_key      = popped_key_q;
	assign popped_priority = popped_prio_q;
	assign status          = status_q;
	assign entry_count     = entry_count_q;

	// Checks
	`IMH_ASSERT_NXT(a_clear_empties, req_valid && !req_stall && req_type == idxh_pkg::REQ_CLEAR, size_q == '0 && present_q == '0, "clear left keys in the heap")
	`IMH_ASSERT_NXT(a_push_marks, req_valid && !req_stall && req_type == idxh_pkg::REQ_PUSH && size_q != idxh_pkg::CNT_W'(idxh_pkg::CAPACITY) && !present_q[key], present_q[$past(key)], "accepted push did not mark its key")
	`IMH_ASSERT_IMP(a_result_from_done, $rose(rsp_valid), $past(state_q) == S_DONE, "result raised outside the finish step")
	`IMH_ASSERT_IMP(a_reject_zero, rsp_valid && status != idxh_pkg::ST_OK, popped_key == '0 && popped_priority == '0, "rejected request carries popped data")

endmodule
